@@ sv/sphere_vortex_direct_sum_unit_macros.svh @@
// assertion helpers used by the sphere_vortex_direct_sum_unit rtl
`ifndef SPHERE_VORTEX_DIRECT_SUM_UNIT_MACROS_SVH
`define SPHERE_VORTEX_DIRECT_SUM_UNIT_MACROS_SVH

// same-cycle implication
`define SVDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/svds_pkg.sv @@
package svds_pkg;

    localparam int SVDS_MAX_SOURCES = 256;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam int DW = 34;
    localparam int KW = 59;
    localparam int CX_W = 35;
    localparam logic [KW-1:0] INV4PI_Q62 = 59'd366986312910250153;

    localparam logic [63:0] SUM_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        point_id;
        logic signed [31:0] source_potential;
        logic [30:0]        source_area;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] sum_x;
        logic signed [63:0] sum_y;
        logic signed [63:0] sum_z;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        id;
        logic signed [31:0] pot;
        logic [30:0]        area;
    } src_t;

    typedef struct packed {
        logic tok;
        logic vld;
        logic last;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [CX_W-1:0] cz;
        logic signed [63:0]     w;
    } div_pay_t;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return {1'b1, (a[63] ? SUM_MIN : SUM_MAX)};
        return {1'b0, s};
    endfunction

endpackage

@@ sv/sphere_vortex_direct_sum_unit.sv @@
// direct vortex velocity sum over stored source points on the unit sphere
//
// command channel: a word is taken on a clock edge with start high and busy
// low. clear and load words finish at that edge and leave busy low, so the
// next word may follow in the next cycle. a load into a full store is dropped.
// an evaluate word raises busy; the source ring then rotates once through all
// MAX_SOURCES cells, one source per cycle into the arithmetic pipeline, and
// the result word appears on result with done high for one cycle, once the
// last source has left the pipeline. busy falls at the edge that raises done,
// so evaluations run one at a time, their length set by the ring length and
// the depth of the bit-per-stage reciprocal.
// the receiver cannot stall: done is a single-cycle strobe and must be taken.
// reset empties the store and drops any evaluation in flight; stored source
// values are not cleared.
module sphere_vortex_direct_sum_unit #(
    parameter int MAX_SOURCES = svds_pkg::SVDS_MAX_SOURCES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  svds_pkg::in_word_t  cmd,
    output logic                done,
    output svds_pkg::out_word_t result
);
    import svds_pkg::*;
    `include "sphere_vortex_direct_sum_unit_macros.svh"

    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SOURCES);
    localparam logic [SW-1:0] STEP_LAST = SW'(MAX_SOURCES - 1);

    logic          busy_reg, issue_reg, done_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] step_reg;
    src_t          tgt_reg;
    out_word_t     result_reg;
    logic [63:0]   sx_reg, sy_reg, sz_reg;
    logic          sat_reg;

    logic accept, do_load, do_clear, do_eval, shift_en, entry_ok, step_last;
    src_t new_src, tail;
    src_t ring_q [MAX_SOURCES];

    assign accept   = start && !busy_reg;
    assign do_clear = accept && cmd.operation == OP_CLEAR;
    assign do_load  = accept && cmd.operation == OP_LOAD && count_reg != CNT_MAX;
    assign do_eval  = accept && cmd.operation == OP_EVAL;
    assign shift_en = do_load || issue_reg;

    assign new_src = '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z, id: cmd.point_id,
                       pot: cmd.source_potential, area: cmd.source_area};
    assign tail = issue_reg ? ring_q[0] : new_src;

    // newest source sits at the tail, oldest valid one at MAX_SOURCES - count
    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_ring
        src_t din;
        if (i == MAX_SOURCES - 1)
        begin : g_tail
            assign din = tail;
        end
        else
        begin : g_mid
            assign din = ring_q[i+1];
        end
        svds_cell u_cell (
            .clk (clk),
            .en  (shift_en),
            .din (din),
            .q   (ring_q[i])
        );
    end

    assign entry_ok  = ((CW+1)'(step_reg) + (CW+1)'(count_reg)) >= (CW+1)'(MAX_SOURCES);
    assign step_last = step_reg == STEP_LAST;

    ctl_t               k_in, k_out;
    logic signed [63:0] term_x, term_y, term_z;

    assign k_in = '{tok: issue_reg, vld: issue_reg && entry_ok,
                    last: issue_reg && step_last, sat: 1'b0};

    svds_kernel u_kernel (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (k_in),
        .src     (ring_q[0]),
        .tgt     (tgt_reg),
        .out_ctl (k_out),
        .term_x  (term_x),
        .term_y  (term_y),
        .term_z  (term_z)
    );

    logic [64:0] ax, ay, az;
    logic [63:0] nx, ny, nz;
    logic        nsat;

    always_comb
    begin
        ax = sat_add(sx_reg, term_x);
        ay = sat_add(sy_reg, term_y);
        az = sat_add(sz_reg, term_z);
        nx = sx_reg;
        ny = sy_reg;
        nz = sz_reg;
        nsat = sat_reg;
        if (k_out.vld)
        begin
            nx = ax[63:0];
            ny = ay[63:0];
            nz = az[63:0];
            nsat = sat_reg | k_out.sat | ax[64] | ay[64] | az[64];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= k_out.tok && k_out.last;
            if (do_clear)
                count_reg <= '0;
            else if (do_load)
                count_reg <= count_reg + CW'(1);
            if (do_eval)
            begin
                busy_reg  <= 1'b1;
                issue_reg <= 1'b1;
                step_reg  <= '0;
            end
            else
            begin
                if (issue_reg)
                begin
                    step_reg <= step_reg + SW'(1);
                    if (step_last)
                        issue_reg <= 1'b0;
                end
                if (k_out.tok && k_out.last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_eval)
        begin
            tgt_reg <= new_src;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else if (k_out.tok)
        begin
            sx_reg  <= nx;
            sy_reg  <= ny;
            sz_reg  <= nz;
            sat_reg <= nsat;
            if (k_out.last)
                result_reg <= '{sum_x: nx, sum_y: ny, sum_z: nz, saturated: nsat};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `SVDS_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "result strobe while still busy")
    `SVDS_ASSERT_NOW(a_issue_busy, issue_reg, busy_reg, "ring rotating while not busy")
    `SVDS_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_MAX, "source count past capacity")
    `SVDS_ASSERT_NEXT(a_eval_start, do_eval, busy_reg && issue_reg, "evaluate did not start")
endmodule

@@ sv/svds_cell.sv @@
module svds_cell (
    input  logic          clk,
    input  logic          en,
    input  svds_pkg::src_t din,
    output svds_pkg::src_t q
);
    import svds_pkg::*;

    src_t q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= din;
    end

    assign q = q_reg;
endmodule

@@ sv/svds_div.sv @@
module svds_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  svds_pkg::ctl_t              in_ctl,
    input  logic [svds_pkg::DW-1:0]     in_den,
    input  svds_pkg::div_pay_t          in_pay,
    output svds_pkg::ctl_t              out_ctl,
    output logic [svds_pkg::KW-1:0]     quot,
    output svds_pkg::div_pay_t          out_pay
);
    import svds_pkg::*;

    ctl_t          ctl_reg [KW];
    logic [DW-1:0] rem_reg [KW];
    logic [DW-1:0] den_reg [KW];
    logic [KW-1:0] quo_reg [KW];
    div_pay_t      pay_reg [KW];

    // one quotient bit of the constant numerator per stage
    for (genvar s = 0; s < KW; s++)
    begin : g_stage
        ctl_t          ctl_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [KW-1:0] quo_in;
        div_pay_t      pay_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (s == 0)
        begin : g_first
            assign ctl_in = in_ctl;
            assign rem_in = '0;
            assign den_in = in_den;
            assign quo_in = '0;
            assign pay_in = in_pay;
        end
        else
        begin : g_rest
            assign ctl_in = ctl_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign pay_in = pay_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_in, INV4PI_Q62[KW-1-s]};
            diff  = trial - {1'b0, den_in};
            take  = trial >= {1'b0, den_in};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s] <= '0;
            else
                ctl_reg[s] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= take ? diff[DW-1:0] : trial[DW-1:0];
            den_reg[s] <= den_in;
            quo_reg[s] <= {quo_in[KW-2:0], take};
            pay_reg[s] <= pay_in;
        end
    end

    assign out_ctl = ctl_reg[KW-1];
    assign quot    = quo_reg[KW-1];
    assign out_pay = pay_reg[KW-1];
endmodule

@@ sv/svds_kernel.sv @@
module svds_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  svds_pkg::ctl_t     in_ctl,
    input  svds_pkg::src_t     src,
    input  svds_pkg::src_t     tgt,
    output svds_pkg::ctl_t     out_ctl,
    output logic signed [63:0] term_x,
    output logic signed [63:0] term_y,
    output logic signed [63:0] term_z
);
    import svds_pkg::*;

    // products
    ctl_t               a_ctl_reg;
    logic signed [63:0] a_dx_reg, a_dy_reg, a_dz_reg;
    logic signed [63:0] a_yz_reg, a_zy_reg, a_zx_reg, a_xz_reg, a_xy_reg, a_yx_reg;
    logic signed [63:0] a_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_ctl_reg <= '0;
        else
            a_ctl_reg <= '{tok: in_ctl.tok, vld: in_ctl.vld && (src.id != tgt.id),
                           last: in_ctl.last, sat: 1'b0};
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg <= tgt.x * src.x;
        a_dy_reg <= tgt.y * src.y;
        a_dz_reg <= tgt.z * src.z;
        a_yz_reg <= tgt.y * src.z;
        a_zy_reg <= tgt.z * src.y;
        a_zx_reg <= tgt.z * src.x;
        a_xz_reg <= tgt.x * src.z;
        a_xy_reg <= tgt.x * src.y;
        a_yx_reg <= tgt.y * src.x;
        a_w_reg  <= src.pot * $signed({1'b0, src.area});
    end

    // denominator and cross terms
    logic signed [35:0]  b_draw;
    logic signed [CX_W-1:0] b_cx, b_cy, b_cz;
    ctl_t                b_ctl_next, b_ctl_reg;
    logic [DW-1:0]       b_den_next, b_den_reg;
    div_pay_t            b_pay_reg;

    always_comb
    begin
        b_draw = (36'sd1 <<< 30)
               - ($signed({{2{a_dx_reg[63]}}, a_dx_reg[63:30]})
               +  $signed({{2{a_dy_reg[63]}}, a_dy_reg[63:30]})
               +  $signed({{2{a_dz_reg[63]}}, a_dz_reg[63:30]}));
        b_cx = $signed({a_yz_reg[63], a_yz_reg[63:30]}) - $signed({a_zy_reg[63], a_zy_reg[63:30]});
        b_cy = $signed({a_zx_reg[63], a_zx_reg[63:30]}) - $signed({a_xz_reg[63], a_xz_reg[63:30]});
        b_cz = $signed({a_xy_reg[63], a_xy_reg[63:30]}) - $signed({a_yx_reg[63], a_yx_reg[63:30]});
        b_ctl_next = a_ctl_reg;
        if (b_draw[35] || b_draw == '0)
        begin
            b_den_next     = DW'(1);
            b_ctl_next.sat = 1'b1;
        end
        else
            b_den_next = b_draw[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctl_reg <= '0;
        else
            b_ctl_reg <= b_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        b_den_reg <= b_den_next;
        b_pay_reg <= '{cx: b_cx, cy: b_cy, cz: b_cz, w: a_w_reg};
    end

    // reciprocal
    ctl_t          d_ctl;
    logic [KW-1:0] d_quot;
    div_pay_t      d_pay;

    svds_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (b_ctl_reg),
        .in_den  (b_den_reg),
        .in_pay  (b_pay_reg),
        .out_ctl (d_ctl),
        .quot    (d_quot),
        .out_pay (d_pay)
    );

    // weight partial products
    logic [63:0]        g1_a;
    ctl_t               g1_ctl_reg;
    logic [63:0]        g1_pp0_reg;
    logic [58:0]        g1_pp1_reg;
    logic signed [64:0] g1_pp2_reg;
    logic signed [59:0] g1_pp3_reg;
    div_pay_t           g1_pay_reg;

    assign g1_a = 64'd0 - d_pay.w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g1_ctl_reg <= '0;
        else
            g1_ctl_reg <= d_ctl;
    end

    always_ff @(posedge clk)
    begin
        g1_pp0_reg <= g1_a[31:0] * d_quot[31:0];
        g1_pp1_reg <= g1_a[31:0] * d_quot[KW-1:32];
        g1_pp2_reg <= $signed(g1_a[63:32]) * $signed({1'b0, d_quot[31:0]});
        g1_pp3_reg <= $signed(g1_a[63:32]) * $signed({1'b0, d_quot[KW-1:32]});
        g1_pay_reg <= d_pay;
    end

    // weight sum, scale and clamp
    logic [127:0]       g2_full;
    logic               g2_ovf;
    ctl_t               g2_ctl_next, g2_ctl_reg;
    logic signed [63:0] g2_g_next, g2_g_reg;
    div_pay_t           g2_pay_reg;

    always_comb
    begin
        g2_full = {64'd0, g1_pp0_reg}
                + {37'd0, g1_pp1_reg, 32'd0}
                + {{31{g1_pp2_reg[64]}}, g1_pp2_reg, 32'd0}
                + {{4{g1_pp3_reg[59]}}, g1_pp3_reg, 64'd0};
        g2_ovf = !((&g2_full[127:102]) || !(|g2_full[127:102]));
        g2_g_next = g2_ovf ? (g2_full[127] ? SUM_MIN : SUM_MAX) : g2_full[102:39];
        g2_ctl_next = g1_ctl_reg;
        g2_ctl_next.sat = g1_ctl_reg.sat | g2_ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g2_ctl_reg <= '0;
        else
            g2_ctl_reg <= g2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        g2_g_reg   <= g2_g_next;
        g2_pay_reg <= g1_pay_reg;
    end

    // term partial products
    ctl_t               t1_ctl_reg;
    logic signed [67:0] t1_lx_reg, t1_ly_reg, t1_lz_reg;
    logic signed [66:0] t1_hx_reg, t1_hy_reg, t1_hz_reg;
    logic signed [32:0] t1_gl;
    logic signed [31:0] t1_gh;

    assign t1_gl = $signed({1'b0, g2_g_reg[31:0]});
    assign t1_gh = $signed(g2_g_reg[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1_ctl_reg <= '0;
        else
            t1_ctl_reg <= g2_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        t1_lx_reg <= g2_pay_reg.cx * t1_gl;
        t1_ly_reg <= g2_pay_reg.cy * t1_gl;
        t1_lz_reg <= g2_pay_reg.cz * t1_gl;
        t1_hx_reg <= g2_pay_reg.cx * t1_gh;
        t1_hy_reg <= g2_pay_reg.cy * t1_gh;
        t1_hz_reg <= g2_pay_reg.cz * t1_gh;
    end

    // term sum, scale and clamp
    logic [99:0]        t2_fx, t2_fy, t2_fz;
    logic               t2_ox, t2_oy, t2_oz;
    ctl_t               t2_ctl_next, t2_ctl_reg;
    logic signed [63:0] t2_x_reg, t2_y_reg, t2_z_reg;

    always_comb
    begin
        t2_fx = {{32{t1_lx_reg[67]}}, t1_lx_reg} + {t1_hx_reg[66], t1_hx_reg, 32'd0};
        t2_fy = {{32{t1_ly_reg[67]}}, t1_ly_reg} + {t1_hy_reg[66], t1_hy_reg, 32'd0};
        t2_fz = {{32{t1_lz_reg[67]}}, t1_lz_reg} + {t1_hz_reg[66], t1_hz_reg, 32'd0};
        t2_ox = !((&t2_fx[99:93]) || !(|t2_fx[99:93]));
        t2_oy = !((&t2_fy[99:93]) || !(|t2_fy[99:93]));
        t2_oz = !((&t2_fz[99:93]) || !(|t2_fz[99:93]));
        t2_ctl_next = t1_ctl_reg;
        t2_ctl_next.sat = t1_ctl_reg.vld & (t1_ctl_reg.sat | t2_ox | t2_oy | t2_oz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t2_ctl_reg <= '0;
        else
            t2_ctl_reg <= t2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        t2_x_reg <= t2_ox ? (t2_fx[99] ? SUM_MIN : SUM_MAX) : t2_fx[93:30];
        t2_y_reg <= t2_oy ? (t2_fy[99] ? SUM_MIN : SUM_MAX) : t2_fy[93:30];
        t2_z_reg <= t2_oz ? (t2_fz[99] ? SUM_MIN : SUM_MAX) : t2_fz[93:30];
    end

    assign out_ctl = t2_ctl_reg;
    assign term_x  = t2_x_reg;
    assign term_y  = t2_y_reg;
    assign term_z  = t2_z_reg;
endmodule
